// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Whenever cond holds, prop holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed: implies");

// Whenever cond holds, prop holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed: next");

`else

`define ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// ----- hdl/cwcs_pkg.sv -----
// Types, constants, CRC and saturating increment functions for the comfort window click sequencer.
`default_nettype none

package cwcs_pkg;

  localparam logic [28:0] FRAME_ID_MATCH = 29'h1EF;
  localparam logic [3:0]  FRAME_LEN_MATCH = 4'd8;

  localparam logic [31:0] CLICK_WINDOW     = 32'd3000;
  localparam logic [31:0] CLOSE_ONE_START  = 32'd4000;
  localparam logic [31:0] CLOSE_ONE_END    = 32'd9000;
  localparam logic [31:0] CLOSE_TWO_START  = 32'd11000;
  localparam logic [31:0] CLOSE_TWO_END    = 32'd11550;
  localparam logic [31:0] OPEN_START       = 32'd3500;
  localparam logic [31:0] OPEN_END         = 32'd8000;

  localparam logic [7:0] CMD_HIGH_NIBBLE = 8'hB0;
  localparam logic [7:0] FOB_MASK        = 8'h1E;
  localparam logic [7:0] REQ_MASK        = 8'h0E;
  localparam logic [7:0] REQ_IGNORED     = 8'h04;

  localparam logic [3:0] ACT_LOCK     = 4'h1;
  localparam logic [3:0] ACT_UNLOCK_A = 4'h3;
  localparam logic [3:0] ACT_UNLOCK_B = 4'h4;

  localparam logic [1:0] MODE_DISABLED  = 2'd0;
  localparam logic [1:0] MODE_ONE_CLICK = 2'd1;

  localparam logic [1:0] STEP_IDLE  = 2'd0;
  localparam logic [1:0] STEP_FIRST = 2'd1;
  localparam logic [1:0] STEP_SECOND = 2'd2;

  localparam logic ACTION_OBSERVE = 1'b0;

  typedef enum logic {
    CFG_CLOSE_SEL = 1'b0,
    CFG_OPEN_SEL  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic        action;
    logic [31:0] now_time;
    logic        is_extended;
    logic [28:0] frame_id;
    logic [3:0]  frame_len;
    logic [63:0] payload;
  } item_t;

  typedef struct packed {
    logic        frame_ready;
    logic [63:0] out_payload;
  } result_t;

  typedef struct packed {
    logic [31:0] last_lock_time;
    logic [31:0] last_unlock_time;
    logic [7:0]  lock_count;
    logic [7:0]  unlock_count;
    logic [7:0]  fob_bits;
    logic [7:0]  requestor_bits;
    logic [1:0]  close_step;
    logic        opening;
  } state_t;

  typedef struct packed {
    logic [1:0] close_sel;
    logic [1:0] open_sel;
  } modes_t;

  // CRC-8 SAE J1850 over bytes 0..6, byte 0 first; init 0xFF, final xor 0xFF.
  function automatic logic [7:0] crc8_j1850(input logic [55:0] data);
    logic [7:0] crc;
    crc = 8'hFF;
    for (int i = 0; i < 7; i++) begin
      crc = crc ^ data[8*i +: 8];
      for (int k = 0; k < 8; k++) begin
        if (crc[7]) begin
          crc = {crc[6:0], 1'b0} ^ 8'h1D;
        end else begin
          crc = {crc[6:0], 1'b0};
        end
      end
    end
    return crc ^ 8'hFF;
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/cwcs_eval.sv -----
// Single-pass evaluation: next state and result for one frame request.
`default_nettype none

module cwcs_eval (
  input  var cwcs_pkg::item_t   item,
  input  var cwcs_pkg::state_t  state,
  input  var cwcs_pkg::modes_t  modes,
  output cwcs_pkg::state_t      state_next,
  output cwcs_pkg::result_t     result
);
  import cwcs_pkg::*;

  logic        match;
  logic [7:0]  b2;
  logic [3:0]  act;
  logic [7:0]  req;
  logic [7:0]  fob;
  logic [31:0] dl;
  logic [31:0] du;
  logic [7:0]  lock_new;
  logic [7:0]  unlock_new;
  logic        is_lock;
  logic        is_unlock;
  logic        send;
  logic [7:0]  patch_b1;
  logic [7:0]  patch_b2;
  logic [55:0] patched;

  assign match = !item.is_extended && (item.frame_id == FRAME_ID_MATCH)
                 && (item.frame_len == FRAME_LEN_MATCH);
  assign b2  = item.payload[23:16];
  assign act = b2[7:4];
  assign req = b2 & REQ_MASK;
  assign fob = item.payload[15:8] & FOB_MASK;
  assign dl  = item.now_time - state.last_lock_time;
  assign du  = item.now_time - state.last_unlock_time;

  assign is_lock   = (act == ACT_LOCK);
  assign is_unlock = ((act == ACT_UNLOCK_A) || (act == ACT_UNLOCK_B)) && (req != REQ_IGNORED);

  // count restarts at 1 only in one-click mode
  assign lock_new = (dl < CLICK_WINDOW) ? sat_inc(state.lock_count)
                  : ((modes.close_sel == MODE_ONE_CLICK) ? 8'd1 : 8'd0);
  assign unlock_new = (du < CLICK_WINDOW) ? sat_inc(state.unlock_count)
                    : ((modes.open_sel == MODE_ONE_CLICK) ? 8'd1 : 8'd0);

  always_comb begin
    state_next = state;
    send       = 1'b0;
    patch_b1   = state.fob_bits;
    patch_b2   = CMD_HIGH_NIBBLE | state.requestor_bits;
    if (match) begin
      if (item.action == ACTION_OBSERVE) begin
        if (is_lock) begin
          state_next.lock_count     = lock_new;
          state_next.last_lock_time = item.now_time;
          state_next.fob_bits       = fob;
          state_next.requestor_bits = req;
          if (lock_new != 8'd0) begin
            state_next.close_step = STEP_FIRST;
          end
          state_next.opening      = 1'b0;
          state_next.unlock_count = 8'd0;
        end else if (is_unlock) begin
          state_next.unlock_count     = unlock_new;
          state_next.last_unlock_time = item.now_time;
          state_next.fob_bits         = fob;
          state_next.requestor_bits   = req;
          state_next.close_step       = STEP_IDLE;
          if ((modes.open_sel != MODE_DISABLED) && (unlock_new != 8'd0)) begin
            state_next.opening = 1'b1;
          end
        end
      end else begin
        if ((state.close_step == STEP_FIRST) && (dl > CLOSE_ONE_START)) begin
          send     = 1'b1;
          patch_b1 = state.fob_bits | 8'h01;
          patch_b2 = state.requestor_bits;
          if (dl > CLOSE_ONE_END) begin
            if (state.lock_count >= 8'd2) begin
              state_next.close_step = STEP_SECOND;
            end else begin
              state_next.close_step = STEP_IDLE;
              state_next.lock_count = 8'd0;
            end
          end
        end else if ((state.close_step == STEP_SECOND) && (dl > CLOSE_TWO_START)) begin
          send = 1'b1;
          if (dl > CLOSE_TWO_END) begin
            state_next.close_step = STEP_IDLE;
            state_next.lock_count = 8'd0;
          end
        end else if (state.opening && (du > OPEN_START)) begin
          send = 1'b1;
          if (du > OPEN_END) begin
            state_next.opening      = 1'b0;
            state_next.unlock_count = 8'd0;
          end
        end
      end
    end
  end

  assign patched = {item.payload[55:24], patch_b2, patch_b1, item.payload[7:0]};

  assign result = '{frame_ready: send,
                    out_payload: (send ? {crc8_j1850(patched), patched} : item.payload)};

endmodule

`default_nettype wire

// ----- hdl/comfort_window_click_sequencer_top.sv -----
// Top level of the comfort window click sequencer.
`default_nettype none

`include "assert_macros.svh"

// Accepts one frame request per clock while the result side is not stalled, and
// returns exactly one result per request. A request is captured in an input
// register; when the result register is free or being taken, a single pass of
// compare, saturating count and CRC-8 logic updates the click state and loads
// the result register, so the rate is set by that one stage. While a finished
// result waits, the input register can still take one more request; after that
// item_ready stays low until the result is taken. The close and open feature
// modes are written through the cfg channel, which is always ready.
module comfort_window_click_sequencer_top (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       item_valid,
  output logic                      item_ready,
  input  var cwcs_pkg::item_t       item,
  output logic                      result_valid,
  input  wire                       result_ready,
  output cwcs_pkg::result_t         result,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  var cwcs_pkg::cfg_index_t  cfg_index,
  input  wire [1:0]                 cfg_data
);
  import cwcs_pkg::*;

  item_t   item_q;
  logic    held_valid;
  logic    advance;
  state_t  state;
  state_t  state_next;
  modes_t  modes;
  result_t eval_result;

  assign cfg_ready  = 1'b1;
  assign advance    = held_valid && (!result_valid || result_ready);
  assign item_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      modes <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CLOSE_SEL: modes.close_sel <= cfg_data;
        CFG_OPEN_SEL:  modes.open_sel  <= cfg_data;
        default:       modes           <= modes;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  cwcs_eval u_eval (
    .item       (item_q),
    .state      (state),
    .modes      (modes),
    .state_next (state_next),
    .result     (eval_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= eval_result;
    end
  end

  // close sequence and window open are never armed together
  `ASSERT_IMPLIES(a_close_open_excl, clk, rst, state.opening, state.close_step == STEP_IDLE)
  `ASSERT_IMPLIES(a_close_step_range, clk, rst, 1'b1, (state.close_step == STEP_IDLE) || (state.close_step == STEP_FIRST) || (state.close_step == STEP_SECOND))
  // a request waiting on a stalled result must not touch the click state
  `ASSERT_NEXT(a_state_hold, clk, rst, held_valid && !advance, $stable(state))

endmodule

`default_nettype wire

// ----- sim/comfort_window_click_sequencer_top_test.sv -----
// Self-checking testbench for the comfort window click sequencer top level.
`timescale 1ns / 1ps

module comfort_window_click_sequencer_top_test;
  import cwcs_pkg::*;

  localparam logic ACTION_BUILD = ~ACTION_OBSERVE;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   LONG_HOLD = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  item_t      item = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = CFG_CLOSE_SEL;
  logic [1:0] cfg_data = 2'd0;

  // predicted block state and mode registers
  state_t st = '0;
  modes_t modes = '0;

  item_t   pend_q[$];
  result_t want_q[$];
  int      queued = 0;
  int      errors = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      hold_left = 0;
  logic    stall_arm = 1'b0;
  logic    stall_seen = 1'b0;
  logic [31:0] now_ms = 32'd0;

  comfort_window_click_sequencer_top dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // CRC-8 J1850, bit serial: byte 0 first, msb first within a byte
  function automatic logic [7:0] frame_crc(input logic [55:0] data);
    logic [7:0] c;
    logic       fb;
    c = 8'hFF;
    for (int i = 0; i < 7; i++) begin
      for (int j = 7; j >= 0; j--) begin
        fb = c[7] ^ data[8*i + j];
        c = {c[6:0], 1'b0} ^ (fb ? 8'h1D : 8'h00);
      end
    end
    return c ^ 8'hFF;
  endfunction

  function automatic logic [63:0] patch_frame(input logic [63:0] p, input logic [7:0] b1,
                                              input logic [7:0] b2);
    p[15:8] = b1;
    p[23:16] = b2;
    p[63:56] = frame_crc(p[55:0]);
    return p;
  endfunction

  task automatic predict_frame(input item_t it, output result_t res);
    logic [3:0]  act;
    logic [7:0]  req, fob;
    logic [31:0] dl, du;
    res.frame_ready = 1'b0;
    res.out_payload = it.payload;
    if (it.is_extended || it.frame_id != FRAME_ID_MATCH || it.frame_len != FRAME_LEN_MATCH)
      return;
    act = it.payload[23:20];
    req = it.payload[23:16] & REQ_MASK;
    fob = it.payload[15:8] & FOB_MASK;
    dl = it.now_time - st.last_lock_time;
    du = it.now_time - st.last_unlock_time;
    if (it.action == ACTION_OBSERVE) begin
      if (act == ACT_LOCK) begin
        if (dl < CLICK_WINDOW) begin
          if (st.lock_count != 8'hFF) st.lock_count = st.lock_count + 8'd1;
        end else begin
          st.lock_count = (modes.close_sel == MODE_ONE_CLICK) ? 8'd1 : 8'd0;
        end
        st.last_lock_time = it.now_time;
        st.fob_bits = fob;
        st.requestor_bits = req;
        if (st.lock_count != 8'd0) st.close_step = STEP_FIRST;
        st.opening = 1'b0;
        st.unlock_count = 8'd0;
      end else if ((act == ACT_UNLOCK_A || act == ACT_UNLOCK_B) && req != REQ_IGNORED) begin
        if (du < CLICK_WINDOW) begin
          if (st.unlock_count != 8'hFF) st.unlock_count = st.unlock_count + 8'd1;
        end else begin
          st.unlock_count = (modes.open_sel == MODE_ONE_CLICK) ? 8'd1 : 8'd0;
        end
        st.last_unlock_time = it.now_time;
        st.fob_bits = fob;
        st.requestor_bits = req;
        st.close_step = STEP_IDLE;
        if (modes.open_sel != MODE_DISABLED && st.unlock_count != 8'd0) st.opening = 1'b1;
      end
    end else if (st.close_step == STEP_FIRST && dl > CLOSE_ONE_START) begin
      res.frame_ready = 1'b1;
      res.out_payload = patch_frame(it.payload, st.fob_bits | 8'h01, st.requestor_bits);
      if (dl > CLOSE_ONE_END) begin
        if (st.lock_count >= 8'd2) begin
          st.close_step = STEP_SECOND;
        end else begin
          st.close_step = STEP_IDLE;
          st.lock_count = 8'd0;
        end
      end
    end else if (st.close_step == STEP_SECOND && dl > CLOSE_TWO_START) begin
      res.frame_ready = 1'b1;
      res.out_payload = patch_frame(it.payload, st.fob_bits,
                                    CMD_HIGH_NIBBLE | st.requestor_bits);
      if (dl > CLOSE_TWO_END) begin
        st.close_step = STEP_IDLE;
        st.lock_count = 8'd0;
      end
    end else if (st.opening && du > OPEN_START) begin
      res.frame_ready = 1'b1;
      res.out_payload = patch_frame(it.payload, st.fob_bits,
                                    CMD_HIGH_NIBBLE | st.requestor_bits);
      if (du > OPEN_END) begin
        st.opening = 1'b0;
        st.unlock_count = 8'd0;
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin : drive_proc
    logic    hold;
    result_t r;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      hold = item_valid && !item_ready;
      if (item_valid && item_ready) begin
        predict_frame(item, r);
        want_q.push_back(r);
      end
      if (!hold) begin
        if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item <= pend_q.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure; a toggle of stall_arm starts a long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (stall_arm != stall_seen) begin
      stall_seen <= stall_arm;
      hold_left <= LONG_HOLD;
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_proc
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (want_q.size() == 0) begin
        $display("%0t ERROR unexpected result, expected none actual %h", $time, result);
        errors++;
      end else begin
        want = want_q.pop_front();
        if (result.frame_ready !== want.frame_ready) begin
          $display("%0t ERROR frame_ready expected %0b actual %0b",
                   $time, want.frame_ready, result.frame_ready);
          errors++;
        end
        if (result.out_payload !== want.out_payload) begin
          $display("%0t ERROR out_payload expected %h actual %h",
                   $time, want.out_payload, result.out_payload);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  function automatic item_t make_item(input logic act, input logic [31:0] t, input logic ext,
                                      input logic [28:0] id, input logic [3:0] len,
                                      input logic [63:0] p);
    item_t it;
    it.action = act;
    it.now_time = t;
    it.is_extended = ext;
    it.frame_id = id;
    it.frame_len = len;
    it.payload = p;
    return it;
  endfunction

  function automatic item_t key_frame(input logic act, input logic [31:0] t,
                                      input logic [63:0] p);
    return make_item(act, t, 1'b0, FRAME_ID_MATCH, FRAME_LEN_MATCH, p);
  endfunction

  // random data with byte 2 set to {action nibble, requestor nibble}
  function automatic logic [63:0] key_payload(input logic [3:0] nib, input logic [3:0] low);
    logic [63:0] p;
    p = {$urandom, $urandom};
    p[23:16] = {nib, low};
    return p;
  endfunction

  function automatic int click_gap(input logic tight);
    if (tight) return $urandom_range(1, 40);
    case ($urandom_range(0, 3))
      0, 1:    return $urandom_range(50, 2999);
      2:       return $urandom_range(2995, 3005);
      default: return $urandom_range(3001, 8000);
    endcase
  endfunction

  task automatic push(input item_t it);
    pend_q.push_back(it);
    if (!it.is_extended && it.frame_id == FRAME_ID_MATCH && it.frame_len == FRAME_LEN_MATCH)
      queued++;
  endtask

  task automatic noise_item();
    logic [63:0] p;
    logic [31:0] t;
    logic        act;
    p = {$urandom, $urandom};
    t = now_ms + $urandom_range(0, 4000);
    act = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: push(make_item(act, $urandom, 1'($urandom_range(0, 1)), 29'($urandom),
                        4'($urandom_range(0, 15)), p));
      1: push(make_item(act, t, 1'b1, FRAME_ID_MATCH, FRAME_LEN_MATCH, p));
      2: push(make_item(act, t, 1'b0, FRAME_ID_MATCH,
                        FRAME_LEN_MATCH ^ 4'($urandom_range(1, 15)), p));
      3: push(make_item(act, t, 1'b0, FRAME_ID_MATCH ^ (29'd1 << $urandom_range(0, 28)),
                        FRAME_LEN_MATCH, p));
      4: push(key_frame(ACTION_OBSERVE, t, key_payload(4'($urandom_range(0, 15)),
                                                       4'($urandom_range(0, 15)))));
      // unlock from the ignored requestor
      5: push(key_frame(ACTION_OBSERVE, t,
                        key_payload($urandom_range(0, 1) ? ACT_UNLOCK_A : ACT_UNLOCK_B,
                                    {3'b010, 1'($urandom_range(0, 1))})));
      6: push(key_frame(ACTION_BUILD, t, p));
      default: now_ms = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 15000);
    endcase
  endtask

  // lock clicks, then build polls across the close windows
  task automatic lock_seq(input int clicks, input logic tight);
    int e, lim, pick;
    for (int k = 0; k < clicks; k++) begin
      now_ms += (k == 0) ? $urandom_range(0, 20000) : click_gap(tight);
      push(key_frame(ACTION_OBSERVE, now_ms,
                     key_payload(ACT_LOCK, 4'($urandom_range(0, 15)))));
    end
    e = 0;
    lim = $urandom_range(9500, 13000);
    while (e < lim) begin
      e += $urandom_range(100, 900);
      case ($urandom_range(0, 3))
        0:       pick = CLOSE_ONE_START;
        1:       pick = CLOSE_ONE_END;
        2:       pick = CLOSE_TWO_START;
        default: pick = CLOSE_TWO_END;
      endcase
      pick += $urandom_range(0, 1);
      if ($urandom_range(0, 7) == 0 && pick > e) e = pick;
      if ($urandom_range(0, 19) == 0) noise_item();
      push(key_frame(ACTION_BUILD, now_ms + e, {$urandom, $urandom}));
    end
    now_ms += e;
  endtask

  // unlock clicks, then build polls across the open window
  task automatic unlock_seq(input int clicks, input logic tight);
    int         e, lim, pick;
    logic [3:0] low;
    for (int k = 0; k < clicks; k++) begin
      now_ms += (k == 0) ? $urandom_range(0, 20000) : click_gap(tight);
      low = 4'($urandom_range(0, 15));
      if (({4'h0, low} & REQ_MASK) == REQ_IGNORED && $urandom_range(0, 5) != 0) low[3] = 1'b1;
      push(key_frame(ACTION_OBSERVE, now_ms,
                     key_payload($urandom_range(0, 1) ? ACT_UNLOCK_A : ACT_UNLOCK_B, low)));
    end
    e = 0;
    lim = $urandom_range(4000, 9000);
    while (e < lim) begin
      e += $urandom_range(100, 900);
      pick = $urandom_range(0, 1) ? OPEN_START : OPEN_END;
      pick += $urandom_range(0, 1);
      if ($urandom_range(0, 5) == 0 && pick > e) e = pick;
      if ($urandom_range(0, 19) == 0) noise_item();
      push(key_frame(ACTION_BUILD, now_ms + e, {$urandom, $urandom}));
    end
    now_ms += e;
  endtask

  task automatic add_random(input int n);
    int target, sel;
    target = queued + n;
    while (queued < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) lock_seq($urandom_range(1, 4), 1'b0);
      else if (sel < 75) unlock_seq($urandom_range(1, 3), 1'b0);
      else repeat ($urandom_range(1, 8)) noise_item();
    end
  endtask

  // starts right after a rising edge
  task automatic write_reg(input cfg_index_t idx, input logic [1:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_CLOSE_SEL) modes.close_sel = v;
    else modes.open_sel = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every request to be sent and every result to arrive
  task automatic drain();
    while (pend_q.size() != 0 || item_valid || want_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic start_phase(input logic [1:0] close_v, input logic [1:0] open_v,
                             input int send_pct, input int recv_pct);
    write_reg(CFG_CLOSE_SEL, close_v);
    write_reg(CFG_OPEN_SEL, open_v);
    @(negedge clk);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  initial begin : main
    logic [31:0] t0, t1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    start_phase(2'd1, 2'd1, 0, 0);
    t0 = 32'h0001_0000;
    // frames that do not match, odd action nibble, ignored requestor, nothing due
    push(make_item(ACTION_OBSERVE, t0, 1'b1, FRAME_ID_MATCH, FRAME_LEN_MATCH,
                   key_payload(ACT_LOCK, 4'hE)));
    push(make_item(ACTION_BUILD, t0, 1'b0, FRAME_ID_MATCH - 29'd1, FRAME_LEN_MATCH,
                   {$urandom, $urandom}));
    push(make_item(ACTION_OBSERVE, t0, 1'b0, FRAME_ID_MATCH, FRAME_LEN_MATCH - 4'd1,
                   key_payload(ACT_LOCK, 4'h2)));
    push(make_item(ACTION_BUILD, 32'hFFFF_FFFF, 1'b1, 29'h1FFF_FFFF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF));
    push(key_frame(ACTION_OBSERVE, t0, key_payload(4'h2, 4'h6)));
    push(key_frame(ACTION_OBSERVE, t0, key_payload(ACT_UNLOCK_A, 4'h5)));
    push(key_frame(ACTION_BUILD, t0, {$urandom, $urandom}));
    // two lock clicks, then polls on both sides of each close boundary
    push(key_frame(ACTION_OBSERVE, t0, 64'hFFFF_FFFF_FF1F_FFFF));
    t1 = t0 + 32'd2999;
    push(key_frame(ACTION_OBSERVE, t1, key_payload(ACT_LOCK, 4'hB)));
    push(key_frame(ACTION_BUILD, t1 + 32'd4000, {$urandom, $urandom}));
    push(key_frame(ACTION_BUILD, t1 + 32'd4001, {$urandom, $urandom}));
    push(key_frame(ACTION_BUILD, t1 + 32'd9000, {$urandom, $urandom}));
    push(key_frame(ACTION_BUILD, t1 + 32'd9001, {$urandom, $urandom}));
    push(key_frame(ACTION_BUILD, t1 + 32'd11000, {$urandom, $urandom}));
    push(key_frame(ACTION_BUILD, t1 + 32'd11001, {$urandom, $urandom}));
    push(key_frame(ACTION_BUILD, t1 + 32'd11551, {$urandom, $urandom}));
    // unlock clicks exactly one window apart, then the open boundaries
    t0 = t1 + 32'd20000;
    push(key_frame(ACTION_OBSERVE, t0, key_payload(ACT_UNLOCK_A, 4'h3)));
    t1 = t0 + 32'd3000;
    push(key_frame(ACTION_OBSERVE, t1, key_payload(ACT_UNLOCK_B, 4'hA)));
    push(key_frame(ACTION_BUILD, t1 + 32'd3500, {$urandom, $urandom}));
    push(key_frame(ACTION_BUILD, t1 + 32'd3501, {$urandom, $urandom}));
    push(key_frame(ACTION_BUILD, t1 + 32'd8001, {$urandom, $urandom}));
    push(key_frame(ACTION_BUILD, t1 + 32'd8500, {$urandom, $urandom}));
    // lock just before the time counter wraps, poll just after it
    push(key_frame(ACTION_OBSERVE, 32'hFFFF_FF00, 64'h0000_0000_0010_0000));
    push(key_frame(ACTION_BUILD, 32'h0000_0F00, 64'h0));
    now_ms = 32'h0000_1000;
    drain();

    // saturating click counts, no idling
    start_phase(2'd2, 2'd2, 0, 0);
    lock_seq(260, 1'b1);
    unlock_seq(260, 1'b1);
    add_random(150);
    drain();

    start_phase(2'd0, 2'd2, 59, 0);
    add_random(350);
    drain();

    start_phase(2'd1, 2'd0, 0, 59);
    add_random(350);
    drain();

    // long result hold-off while requests keep coming
    start_phase(2'd2, 2'd1, 29, 29);
    add_random(150);
    stall_arm <= ~stall_arm;
    add_random(200);
    drain();

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
